// ===== design/krr_pkg.sv =====
// Package with the constants, types and command structs of the keyed round-robin member table.
`default_nettype none
package krr_pkg;
  localparam int MaxGroups = 16;
  localparam int MaxMembers = 8;
  localparam int GW = $clog2(MaxGroups);
  localparam int MW = $clog2(MaxMembers);
  localparam int CW = $clog2(MaxMembers + 1);
  localparam int AW = GW + MW;

  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeRemove = 2'd1;
  localparam logic [1:0] ModeNext = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StDuplicate = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_GSCAN, S_DISPATCH, S_MSCAN, S_MWAIT, S_ADD_NEW, S_APPEND,
    S_NEXT_RD, S_NEXT_WAIT, S_SHIFT_RD, S_SHIFT_WAIT, S_REM_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic gscan_clr;
    logic gscan_step;
    logic mscan_clr;
    logic mem_rd;
    logic add_new;
    logic append;
    logic next_adv;
    logic shift_wr;
    logic rem_fin;
    logic clear_all;
    logic set_result;
    logic [1:0] res_status;
    logic use_rdata;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic gscan_done;
    logic gfound;
    logic free_found;
    logic mscan_done;
    logic mhit;
    logic group_full;
    logic next_ok;
    logic shift_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/keyed_round_robin_member_table.sv =====
// Top level of the keyed round-robin member table.
// A clear does not wait for the key scan and is answered after the dispatch step; any other
// item runs a key scan of the group table, a dispatch step, then, where needed, a member scan,
// a shift or a read of the next member through the single-port member memory, and the strobe.
// One item is worked on at a time; busy stays high through the strobe cycle, so the next
// transfer can come in the cycle after it. Reset empties the table; the receiver cannot stall.
`default_nettype none
module keyed_round_robin_member_table (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] mode,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  input  wire logic [31:0] member_id,
  output logic done,
  output logic [1:0] status,
  output logic [31:0] next_member
);
  import krr_pkg::*;
  cmd_t cmd;
  stat_t st;

  krr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .st(st), .done(done)
  );

  krr_dp u_dp (
    .clk(clk), .rst(rst), .mode(mode), .key_high(key_high), .key_low(key_low),
    .member_id(member_id), .cmd(cmd), .st(st), .status(status), .next_member(next_member)
  );
endmodule
`default_nettype wire

// ===== design/krr_ctrl.sv =====
// Controller state machine that sequences the searches and updates of the member table.
`default_nettype none
module krr_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  output krr_pkg::cmd_t cmd,
  input  krr_pkg::stat_t st,
  output logic done
);
  import krr_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.gscan_clr = 1'b1;
          state_next = S_GSCAN;
        end
      end
      S_GSCAN: begin
        cmd.gscan_step = 1'b1;
        if (st.mode == ModeClear) begin
          state_next = S_DISPATCH;
        end else if (st.gscan_done) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.mscan_clr = 1'b1;
        if (st.mode == ModeClear) begin
          cmd.clear_all = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_status = StOk;
          state_next = S_DONE;
        end else if (!st.gfound) begin
          cmd.set_result = 1'b1;
          if (st.mode == ModeAdd) begin
            if (st.free_found) begin
              state_next = S_ADD_NEW;
            end else begin
              cmd.res_status = StFull;
              state_next = S_DONE;
            end
          end else begin
            cmd.res_status = StNotFound;
            state_next = S_DONE;
          end
          if (st.mode == ModeAdd && st.free_found) begin
            cmd.set_result = 1'b0;
          end
        end else if (st.mode == ModeNext) begin
          state_next = S_NEXT_RD;
        end else begin
          state_next = S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (st.mscan_done) begin
          if (st.mode == ModeAdd) begin
            if (st.group_full) begin
              cmd.set_result = 1'b1;
              cmd.res_status = StFull;
              state_next = S_DONE;
            end else begin
              state_next = S_APPEND;
            end
          end else begin
            cmd.set_result = 1'b1;
            cmd.res_status = StNotFound;
            state_next = S_DONE;
          end
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (st.mhit) begin
          if (st.mode == ModeAdd) begin
            cmd.set_result = 1'b1;
            cmd.res_status = StDuplicate;
            state_next = S_DONE;
          end else begin
            state_next = S_SHIFT_RD;
          end
        end else begin
          state_next = S_MSCAN;
        end
      end
      S_ADD_NEW: begin
        cmd.add_new = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_status = StOk;
        state_next = S_DONE;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_status = StOk;
        state_next = S_DONE;
      end
      S_NEXT_RD: begin
        if (st.next_ok) begin
          cmd.mem_rd = 1'b1;
          state_next = S_NEXT_WAIT;
        end else begin
          cmd.set_result = 1'b1;
          cmd.res_status = StNotFound;
          state_next = S_DONE;
        end
      end
      S_NEXT_WAIT: begin
        cmd.next_adv = 1'b1;
        cmd.set_result = 1'b1;
        cmd.use_rdata = 1'b1;
        cmd.res_status = StOk;
        state_next = S_DONE;
      end
      S_SHIFT_RD: begin
        if (st.shift_done) begin
          state_next = S_REM_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_REM_FIN: begin
        cmd.rem_fin = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_status = StOk;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== design/krr_dp.sv =====
// Datapath with the group table, the member memory, the scan counters and the result registers.
`default_nettype none
module krr_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] mode,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  input  wire logic [31:0] member_id,
  input  krr_pkg::cmd_t cmd,
  output krr_pkg::stat_t st,
  output logic [1:0] status,
  output logic [31:0] next_member
);
  import krr_pkg::*;

  logic [1:0] r_mode;
  logic [63:0] r_kh, r_kl;
  logic [31:0] r_id;

  logic [MaxGroups-1:0] gvalid;
  logic [63:0] gkh [MaxGroups];
  logic [63:0] gkl [MaxGroups];
  logic [CW-1:0] gcount [MaxGroups];
  logic [MW-1:0] gptr [MaxGroups];
  logic [31:0] mem [MaxGroups*MaxMembers];
  logic [31:0] rdata;

  logic [GW:0] gi;
  logic gfound, free_found;
  logic [GW-1:0] gsel, gfree;
  logic [CW-1:0] mi;
  logic [MW-1:0] hit_idx;
  logic [MW-1:0] rem_idx;
  logic [CW-1:0] cnt;
  logic [MW-1:0] ptr;
  logic [AW-1:0] rd_addr;

  assign cnt = gcount[gsel];
  assign ptr = gptr[gsel];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode;
      r_kh <= key_high;
      r_kl <= key_low;
      r_id <= member_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gi <= '0;
      gfound <= 1'b0;
      free_found <= 1'b0;
      gsel <= '0;
      gfree <= '0;
    end else if (cmd.gscan_clr) begin
      gi <= '0;
      gfound <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.gscan_step && gi < (GW+1)'(MaxGroups)) begin
      if (!gfound && gvalid[gi[GW-1:0]] && gkh[gi[GW-1:0]] == r_kh
          && gkl[gi[GW-1:0]] == r_kl) begin
        gfound <= 1'b1;
        gsel <= gi[GW-1:0];
      end
      if (!free_found && !gvalid[gi[GW-1:0]]) begin
        free_found <= 1'b1;
        gfree <= gi[GW-1:0];
      end
      gi <= gi + 1'b1;
    end
  end

  always_comb begin
    rd_addr = {gsel, hit_idx};
    if (r_mode == ModeNext) begin
      rd_addr = {gsel, ptr};
    end else if (cmd.mem_rd && st.mhit == 1'b0 && r_mode != ModeNext) begin
      rd_addr = {gsel, mi[MW-1:0]};
    end
  end

  logic shifting;
  always_ff @(posedge clk) begin
    if (rst) begin
      mi <= '0;
      hit_idx <= '0;
      shifting <= 1'b0;
    end else if (cmd.mscan_clr) begin
      mi <= '0;
      shifting <= 1'b0;
    end else if (cmd.mem_rd && !shifting && r_mode != ModeNext) begin
      mi <= mi + 1'b1;
    end else if (st.mhit && !shifting) begin
      shifting <= 1'b1;
    end else if (cmd.shift_wr) begin
      hit_idx <= hit_idx + 1'b1;
    end
    if (!rst && !cmd.mscan_clr && !shifting && rdata == r_id
        && cmd.mem_rd == 1'b0 && r_mode != ModeNext && mi != '0) begin
      hit_idx <= MW'(mi - 1'b1);
      rem_idx <= MW'(mi - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      if (shifting) begin
        rdata <= mem[{gsel, MW'(hit_idx + 1'b1)}];
      end else begin
        rdata <= mem[rd_addr];
      end
    end
    if (cmd.add_new) begin
      mem[{gfree, {MW{1'b0}}}] <= r_id;
    end else if (cmd.append) begin
      mem[{gsel, cnt[MW-1:0]}] <= r_id;
    end else if (cmd.shift_wr) begin
      mem[{gsel, hit_idx}] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_new) begin
      gkh[gfree] <= r_kh;
      gkl[gfree] <= r_kl;
    end
  end

  logic [CW-1:0] n1;
  logic [MW-1:0] p_rem;
  assign n1 = cnt - 1'b1;
  always_comb begin
    p_rem = ptr;
    if (rem_idx < ptr) begin
      p_rem = ptr - 1'b1;
    end
    if (CW'(rem_idx) == CW'(p_rem) && CW'(rem_idx) == n1) begin
      p_rem = '0;
    end
  end

  logic [MW-1:0] p_next;
  always_comb begin
    p_next = '0;
    if (CW'(ptr) + 1'b1 < cnt) begin
      p_next = ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      gvalid <= '0;
      for (int g = 0; g < MaxGroups; g++) begin
        gcount[g] <= '0;
        gptr[g] <= '0;
      end
    end else if (cmd.add_new) begin
      gvalid[gfree] <= 1'b1;
      gcount[gfree] <= CW'(1);
      gptr[gfree] <= '0;
    end else if (cmd.append) begin
      gcount[gsel] <= cnt + 1'b1;
    end else if (cmd.next_adv) begin
      gptr[gsel] <= p_next;
    end else if (cmd.rem_fin) begin
      gcount[gsel] <= n1;
      if (n1 == '0) begin
        gvalid[gsel] <= 1'b0;
        gptr[gsel] <= '0;
      end else begin
        gptr[gsel] <= p_rem;
      end
    end
  end

  logic mhit_r;
  always_ff @(posedge clk) begin
    if (rst || cmd.mscan_clr) begin
      mhit_r <= 1'b0;
    end else if (cmd.shift_wr || shifting) begin
      mhit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      status <= cmd.res_status;
      next_member <= cmd.use_rdata ? rdata : 32'd0;
    end
  end

  always_comb begin
    st.mode = r_mode;
    st.gscan_done = (gi == (GW+1)'(MaxGroups));
    st.gfound = gfound;
    st.free_found = free_found;
    st.mscan_done = (mi >= cnt);
    st.mhit = (rdata == r_id) && !shifting && !mhit_r && mi != '0;
    st.group_full = (cnt >= CW'(MaxMembers));
    st.next_ok = (cnt != '0) && (CW'(ptr) < cnt);
    st.shift_done = (CW'(hit_idx) + 1'b1 >= cnt);
  end
endmodule
`default_nettype wire
